// ===== src/phmm_pkg.sv =====
// Shared types and codes for the protected halfword main memory.
`timescale 1ns / 1ps

package phmm_pkg;

  // Access kinds carried on the mode field
  typedef enum logic [2:0] {
    MODE_READ16  = 3'd0,
    MODE_READ32  = 3'd1,
    MODE_WRITE16 = 3'd2,
    MODE_WRITE32 = 3'd3,
    MODE_SETPROT = 3'd4,
    MODE_QUERY   = 3'd5
  } mode_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // One bank entry: store-protect bit and halfword data
  typedef struct packed {
    logic        prot;
    logic [15:0] data;
  } entry_t;

  localparam int unsigned WordsInUseW = 17;
  localparam logic [WordsInUseW-1:0] WordsInUseReset = 17'h10000;

endpackage

// ===== src/protected_halfword_main_memory.sv =====
// Top level of the protected halfword main memory.
// Usage:
//   Request channel (req_valid / req_stall) carries one access: mode, address,
//   write_value, check_protect, protect_value. Response channel (rsp_valid /
//   rsp_stall) returns read_data, write_accepted and protect_flag, one response
//   per request, in order. cfg_write_en / cfg_write_data set words_in_use.
// Storage is two banks of MAX_WORDS rows (even and odd halfwords), each row a
// 16-bit halfword plus its protect bit, so a word touches both banks at once.
// The accepting edge reads both banks; the execute step then waits while a
// stalled response holds the response register, does the protect check,
// writes back and loads the response register. No new request is taken until
// the current one has written back, as each bank reads and then writes on its
// single port pair. After rst the block clears both banks, one row a cycle;
// req_stall stays high meanwhile. The response register decouples the sides:
// a request is taken while a finished response waits, and a stalled response
// holds its value until transferred.
`timescale 1ns / 1ps

module protected_halfword_main_memory #(
  parameter int MAX_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [16:0] cfg_write_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  mode,
  input  logic [18:0] address,
  input  logic [31:0] write_value,
  input  logic        check_protect,
  input  logic        protect_value,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] read_data,
  output logic        write_accepted,
  output logic        protect_flag
);
  import phmm_pkg::*;

  localparam int RowW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam logic [18:0] MaxWords = 19'(MAX_WORDS);
  localparam logic [RowW-1:0] LastRow = RowW'(MAX_WORDS - 1);

  state_t state, state_next;
  logic [WordsInUseW-1:0] words_in_use;
  logic [RowW-1:0] clear_row;
  logic commit;
  logic accept;

  // Accepted item
  mode_t item_mode;
  logic item_lsb, item_check, item_pval, item_even_present, item_odd_present;
  logic [31:0] item_value;
  logic [RowW-1:0] item_even_row, item_odd_row;

  // Request decode
  logic [18:0] addr_eff;
  logic [19:0] addr_plus;
  logic [18:0] even_row_full, odd_row_full, limit;
  logic even_present_now, odd_present_now;

  // Bank ports
  logic even_we, odd_we;
  logic [RowW-1:0] even_wrow, odd_wrow;
  entry_t even_wd, odd_wd, even_rd, odd_rd;

  // Execute step
  entry_t e0, e1, wd0, wd1;
  logic p0, p1, prot0, prot1, wr0, wr1;
  logic [15:0] d0, d1;
  logic [31:0] rd_result;
  logic acc_result, flag_result;

  assign accept = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);

  // Hold the size register
  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= WordsInUseReset;
    end else if (cfg_write_en) begin
      words_in_use <= cfg_write_data;
    end
  end

  // Locate both halfwords a request can touch
  always_comb begin
    addr_eff = (mode_t'(mode) == MODE_READ32) ? {address[18:1], 1'b0} : address;
    addr_plus = {1'b0, addr_eff} + 20'd1;
    even_row_full = addr_plus[19:1];
    odd_row_full = {1'b0, addr_eff[18:1]};
    limit = ({2'b00, words_in_use} > MaxWords) ? MaxWords : {2'b00, words_in_use};
    even_present_now = even_row_full < limit;
    odd_present_now = odd_row_full < limit;
  end

  // Capture the request on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode <= mode_t'(mode);
      item_lsb <= addr_eff[0];
      item_value <= write_value;
      item_check <= check_protect;
      item_pval <= protect_value;
      item_even_row <= even_row_full[RowW-1:0];
      item_odd_row <= odd_row_full[RowW-1:0];
      item_even_present <= even_present_now;
      item_odd_present <= odd_present_now;
    end
  end

  // State register and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clear_row <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_row <= clear_row + RowW'(1);
      end
    end
  end

  // Next state and commit strobe
  always_comb begin
    state_next = state;
    commit = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clear_row == LastRow) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!rsp_valid || !rsp_stall) begin
          commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Check protection, build the response and the write-back entries
  always_comb begin
    e0 = item_lsb ? odd_rd : even_rd;
    e1 = item_lsb ? even_rd : odd_rd;
    p0 = item_lsb ? item_odd_present : item_even_present;
    p1 = item_lsb ? item_even_present : item_odd_present;
    prot0 = p0 && e0.prot;
    prot1 = p1 && e1.prot;
    d0 = p0 ? e0.data : 16'h0000;
    d1 = p1 ? e1.data : 16'h0000;
    rd_result = 32'h0;
    acc_result = 1'b1;
    flag_result = 1'b0;
    wr0 = 1'b0;
    wr1 = 1'b0;
    wd0 = e0;
    wd1 = e1;
    unique case (item_mode)
      MODE_READ16: rd_result = {16'h0000, d0};
      MODE_READ32: rd_result = {d0, d1};
      MODE_WRITE16: begin
        if (item_check && prot0) begin
          acc_result = 1'b0;
        end else begin
          wr0 = p0;
          wd0.data = item_value[15:0];
        end
      end
      MODE_WRITE32: begin
        if (item_check && (prot0 || prot1)) begin
          acc_result = 1'b0;
        end else begin
          wr0 = p0;
          wr1 = p1;
          wd0.data = item_value[31:16];
          wd1.data = item_value[15:0];
        end
      end
      MODE_SETPROT: begin
        wr0 = p0;
        wd0.prot = item_pval;
      end
      MODE_QUERY: flag_result = prot0;
      default: ;
    endcase
  end

  // Route writes to the banks; zero rows during the clear pass
  always_comb begin
    if (state == ST_CLEAR) begin
      even_we = 1'b1;
      odd_we = 1'b1;
      even_wrow = clear_row;
      odd_wrow = clear_row;
      even_wd = '0;
      odd_wd = '0;
    end else begin
      even_we = commit && (item_lsb ? wr1 : wr0);
      odd_we = commit && (item_lsb ? wr0 : wr1);
      even_wrow = item_even_row;
      odd_wrow = item_odd_row;
      even_wd = item_lsb ? wd1 : wd0;
      odd_wd = item_lsb ? wd0 : wd1;
    end
  end

  phmm_bank #(
    .DEPTH (MAX_WORDS),
    .ROW_W (RowW)
  ) u_even_bank (
    .clk     (clk),
    .wr_en   (even_we),
    .wr_row  (even_wrow),
    .wr_data (even_wd),
    .rd_en   (accept),
    .rd_row  (even_row_full[RowW-1:0]),
    .rd_data (even_rd)
  );

  phmm_bank #(
    .DEPTH (MAX_WORDS),
    .ROW_W (RowW)
  ) u_odd_bank (
    .clk     (clk),
    .wr_en   (odd_we),
    .wr_row  (odd_wrow),
    .wr_data (odd_wd),
    .rd_en   (accept),
    .rd_row  (odd_row_full[RowW-1:0]),
    .rd_data (odd_rd)
  );

  // Response register: load on commit, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      read_data <= rd_result;
      write_accepted <= acc_result;
      protect_flag <= flag_result;
    end
  end

`ifndef SYNTHESIS
  // A transfer always moves the sequencer into the execute step
  assert property (@(posedge clk) disable iff (rst) accept |=> state == ST_EXEC)
    else $error("request transfer not followed by execute step");

  // A new response appears only out of the execute step
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_EXEC)
    else $error("response raised outside execute step");

  // Banks are never written while idle
  assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !even_we && !odd_we)
    else $error("bank write while idle");
`endif

endmodule

// ===== src/phmm_bank.sv =====
// One halfword bank: synchronous memory with one write port and one registered read port.
`timescale 1ns / 1ps

module phmm_bank #(
  parameter int DEPTH = 65536,
  parameter int ROW_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ROW_W-1:0]   wr_row,
  input  phmm_pkg::entry_t   wr_data,
  input  logic               rd_en,
  input  logic [ROW_W-1:0]   rd_row,
  output phmm_pkg::entry_t   rd_data
);
  import phmm_pkg::*;

  entry_t mem [DEPTH];

  // Write the addressed row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  // Registered read; hold the last read otherwise
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule
